### hdl/kio_pkg.sv
// kio_pkg: shared constants, word types and scan result type for the keyed index.
// Used by kio_mem, kio_scan and keyed_index_oldest_eviction; depends on nothing.
`default_nettype none
package kio_pkg;

  localparam int ENTRIES  = 64;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int LIM_W    = 7;
  localparam int CMP_W    = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 64;
  localparam int BYTES_W  = 32;
  localparam int TOK_W    = 20;
  localparam int STAMP_W  = 48;

  localparam logic [LIM_W-1:0]  LIMIT_RST   = 7'd64;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key_hash;
    logic [BYTES_W-1:0] blob_bytes;
    logic [TOK_W-1:0]   prefix_tokens;
    logic [BYTES_W-1:0] room_bytes;
  } in_word_t;

  typedef struct packed {
    logic               ok;
    logic [BYTES_W-1:0] found_bytes;
    logic [TOK_W-1:0]   found_tokens;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_hash;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [BYTES_W-1:0] bytes;
    logic [TOK_W-1:0]   tokens;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   match_idx;
    logic [BYTES_W-1:0] match_bytes;
    logic [TOK_W-1:0]   match_tokens;
    logic [CNT_W-1:0]   n_valid;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               best_vld;
    logic [IDX_W-1:0]   best_idx;
    logic [STAMP_W-1:0] best_age;
    logic [KEY_W-1:0]   best_key;
  } scan_res_t;

endpackage
`default_nettype wire

### hdl/kio_mem.sv
// kio_mem: entry store, one write port and one registered read port.
// Depends on kio_pkg for the entry type and depth.
`default_nettype none
module kio_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [kio_pkg::IDX_W-1:0] wr_addr,
  input  kio_pkg::entry_t           wr_data,
  input  logic [kio_pkg::IDX_W-1:0] rd_addr,
  output kio_pkg::entry_t           rd_data
);

  kio_pkg::entry_t mem [kio_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/kio_scan.sv
// kio_scan: per-entry compare unit; key match, valid count, first free slot, oldest entry.
// Evaluates one entry a cycle and accumulates the result; depends on kio_pkg.
`default_nettype none
module kio_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        step,
  input  logic [kio_pkg::IDX_W-1:0]   idx,
  input  logic                        ent_vld,
  input  kio_pkg::entry_t             ent,
  input  logic [kio_pkg::KEY_W-1:0]   key,
  input  logic [kio_pkg::STAMP_W-1:0] stamp_now,
  input  logic                        is_store,
  output kio_pkg::scan_res_t          res
);

  kio_pkg::scan_res_t res_r;
  kio_pkg::scan_res_t res_nxt;
  logic                        hit;
  logic [kio_pkg::STAMP_W-1:0] age;

  assign hit = ent_vld && (ent.key == key);
  // rewritten entry counts as newest
  assign age = (hit && is_store) ? '0 : (stamp_now - ent.stamp);

  always_comb begin
    res_nxt = res_r;
    if (clr) begin
      res_nxt = '0;
    end else if (step) begin
      if (hit && !res_r.found) begin
        res_nxt.found        = 1'b1;
        res_nxt.match_idx    = idx;
        res_nxt.match_bytes  = ent.bytes;
        res_nxt.match_tokens = ent.tokens;
      end
      if (ent_vld) begin
        res_nxt.n_valid = res_r.n_valid + kio_pkg::CNT_W'(1);
        if (!res_r.best_vld || (age > res_r.best_age)) begin
          res_nxt.best_vld = 1'b1;
          res_nxt.best_idx = idx;
          res_nxt.best_age = age;
          res_nxt.best_key = ent.key;
        end
      end else if (!res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

### hdl/keyed_index_oldest_eviction.sv
// keyed_index_oldest_eviction: associative index with oldest-write eviction, top level.
// Holds sequencer, valid bits, stamp counter and limit; uses kio_pkg, kio_mem, kio_scan.
//
//   channel | handshake          | word
//   in      | in_valid/in_stall  | kio_pkg::in_word_t
//   out     | out_valid/out_stall| kio_pkg::out_word_t
//   cfg     | cfg_valid/cfg_ready| entry_limit, 7 bits
//
// Each word is scanned with one entry store read per cycle, which feeds the
// shared compare unit; then the commit state applies the update and loads the result.
// Reset clears valid bits, stamp counter and sequencer; limit resets to 64.
// A stalled result holds in the output register; the next word is taken meanwhile
// and waits in the commit cycle until the output register frees.
`default_nettype none
module keyed_index_oldest_eviction (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kio_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kio_pkg::out_word_t            out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kio_pkg::LIM_W-1:0]     cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [kio_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        scan_vld_r;
  logic [kio_pkg::IDX_W-1:0]   scan_idx_r;
  kio_pkg::in_word_t           item_r;
  logic [kio_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [kio_pkg::STAMP_W-1:0] wc_r, wc_nxt;
  logic [kio_pkg::LIM_W-1:0]   limit_r;
  logic                        out_vld_r;
  kio_pkg::out_word_t          out_word_r, out_word_nxt;

  kio_pkg::entry_t             rd_data;
  kio_pkg::entry_t             wr_data;
  kio_pkg::scan_res_t          res;
  logic                        in_acc;
  logic                        fin_go;
  logic                        is_store;
  logic                        store_ok;
  logic                        evict_do;
  logic                        hit_ok;
  logic [kio_pkg::IDX_W-1:0]   slot;
  logic [kio_pkg::CMP_W-1:0]   lim_cmp;
  logic [kio_pkg::CMP_W-1:0]   n_cmp;
  logic                        scan_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  assign is_store  = (item_r.kind == kio_pkg::KIND_STORE);
  assign store_ok  = is_store && (item_r.blob_bytes != '0);
  assign scan_last = scan_vld_r && (scan_idx_r == kio_pkg::IDX_W'(kio_pkg::ENTRIES - 1));
  assign fin_go    = (state_r == S_FIN) && (!out_vld_r || !out_stall);

  kio_mem u_mem (
    .clk     (clk),
    .wr_en   (fin_go && store_ok),
    .wr_addr (slot),
    .wr_data (wr_data),
    .rd_addr (cnt_r[kio_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  kio_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (in_acc),
    .step      (scan_vld_r),
    .idx       (scan_idx_r),
    .ent_vld   (valid_r[scan_idx_r]),
    .ent       (rd_data),
    .key       (item_r.key_hash),
    .stamp_now (wc_r),
    .is_store  (is_store),
    .res       (res)
  );

  always_comb begin
    if (limit_r == '0) begin
      lim_cmp = kio_pkg::CMP_W'(1);
    end else if (kio_pkg::CMP_W'(limit_r) > kio_pkg::CMP_W'(kio_pkg::ENTRIES)) begin
      lim_cmp = kio_pkg::CMP_W'(kio_pkg::ENTRIES);
    end else begin
      lim_cmp = kio_pkg::CMP_W'(limit_r);
    end
    n_cmp    = kio_pkg::CMP_W'(res.n_valid);
    evict_do = store_ok && res.best_vld &&
               (res.found ? (n_cmp > lim_cmp) : (n_cmp >= lim_cmp));
    if (res.found) begin
      slot = res.match_idx;
    end else if (evict_do && (!res.free_found || (res.best_idx < res.free_idx))) begin
      slot = res.best_idx;
    end else begin
      slot = res.free_idx;
    end
    wr_data.key    = item_r.key_hash;
    wr_data.bytes  = item_r.blob_bytes;
    wr_data.tokens = item_r.prefix_tokens;
    wr_data.stamp  = wc_r;
    hit_ok = (item_r.kind == kio_pkg::KIND_LOOKUP) && res.found &&
             (res.match_bytes <= item_r.room_bytes);
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    valid_nxt    = valid_r;
    wc_nxt       = wc_r;
    out_word_nxt = out_word_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != kio_pkg::CNT_W'(kio_pkg::ENTRIES)) begin
          cnt_nxt = cnt_r + kio_pkg::CNT_W'(1);
        end
        if (scan_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
          if (store_ok) begin
            if (evict_do) begin
              valid_nxt[res.best_idx] = 1'b0;
            end
            if (!res.found) begin
              valid_nxt[slot] = 1'b1;
            end
            wc_nxt = wc_r + kio_pkg::STAMP_W'(1);
          end
          if ((item_r.kind == kio_pkg::KIND_REMOVE) && res.found) begin
            valid_nxt[res.match_idx] = 1'b0;
          end
          out_word_nxt.ok = store_ok || hit_ok ||
                            ((item_r.kind == kio_pkg::KIND_REMOVE) && res.found);
          out_word_nxt.found_bytes  = hit_ok ? res.match_bytes : '0;
          out_word_nxt.found_tokens = hit_ok ? res.match_tokens : '0;
          out_word_nxt.evicted      = evict_do;
          out_word_nxt.evicted_hash = evict_do ? res.best_key : '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      scan_vld_r <= 1'b0;
      valid_r    <= '0;
      wc_r       <= '0;
      limit_r    <= kio_pkg::LIMIT_RST;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      scan_vld_r <= (state_r == S_SCAN) && (cnt_r != kio_pkg::CNT_W'(kio_pkg::ENTRIES));
      valid_r    <= valid_nxt;
      wc_r       <= wc_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (fin_go) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= cnt_r[kio_pkg::IDX_W-1:0];
    out_word_r <= out_word_nxt;
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FIN && !out_vld_r) |=> !out_vld_r)
    else $error("result appeared outside commit");

  a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (cnt_r == kio_pkg::CNT_W'(kio_pkg::ENTRIES)))
    else $error("commit before full scan");

  a_stamp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> ((wc_r == $past(wc_r) + kio_pkg::STAMP_W'(1)) == $past(store_ok)))
    else $error("stamp counter out of step with stores");

  a_evict_store: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go && evict_do |=> ($countones(valid_r) <= $countones($past(valid_r))))
    else $error("eviction grew the index");

endmodule
`default_nettype wire

### test/keyed_index_checker.sv
// keyed_index_checker: watches the in, out and cfg channels of the keyed index,
// predicts each result word from its own copy of the table and compares them in order.
// Depends on kio_pkg for word types, kind codes and sizes.
module keyed_index_checker
  import kio_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [LIM_W-1:0]     cfg_data,
  output int                   fails,
  output int                   pending
);

  logic               tbl_valid  [ENTRIES];
  logic [KEY_W-1:0]   tbl_key    [ENTRIES];
  logic [BYTES_W-1:0] tbl_bytes  [ENTRIES];
  logic [TOK_W-1:0]   tbl_tokens [ENTRIES];
  logic [STAMP_W-1:0] tbl_stamp  [ENTRIES];
  logic [STAMP_W-1:0] wr_count;
  logic [LIM_W-1:0]   limit_reg;

  out_word_t pending_results [$];
  out_word_t want;

  function automatic int find_slot(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    end
    return -1;
  endfunction

  // drop the entry with the largest age; lowest slot wins a tie
  function automatic void evict_oldest(inout out_word_t r);
    int best;
    logic [STAMP_W-1:0] best_age;
    logic [STAMP_W-1:0] age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        age = wr_count - tbl_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i;
          best_age = age;
        end
      end
    end
    if (best >= 0) begin
      tbl_valid[best] = 1'b0;
      r.evicted = 1'b1;
      r.evicted_hash = tbl_key[best];
    end
  endfunction

  function automatic out_word_t index_step(in_word_t w);
    out_word_t r;
    int lim;
    int held;
    int slot;
    r = '0;
    lim = (limit_reg == '0) ? 1 : (limit_reg > ENTRIES) ? ENTRIES : int'(limit_reg);
    slot = find_slot(w.key_hash);
    case (w.kind)
      KIND_STORE: begin
        if (w.blob_bytes != '0) begin
          held = 0;
          foreach (tbl_valid[i]) if (tbl_valid[i]) held++;
          if (slot < 0) begin
            if (held + 1 > lim) evict_oldest(r);
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (!tbl_valid[i]) slot = i;
            end
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = w.key_hash;
          end else if (held > lim) begin
            tbl_stamp[slot] = wr_count;
            evict_oldest(r);
          end
          tbl_bytes[slot] = w.blob_bytes;
          tbl_tokens[slot] = w.prefix_tokens;
          tbl_stamp[slot] = wr_count;
          wr_count = wr_count + 1'b1;
          r.ok = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (slot >= 0 && tbl_bytes[slot] <= w.room_bytes) begin
          r.ok = 1'b1;
          r.found_bytes = tbl_bytes[slot];
          r.found_tokens = tbl_tokens[slot];
        end
      end
      KIND_REMOVE: begin
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      wr_count = '0;
      limit_reg = LIMIT_RST;
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word %p", out_word);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (out_word.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_word.ok);
            fails++;
          end
          if (out_word.found_bytes !== want.found_bytes) begin
            $error("found_bytes: expected %0h, got %0h", want.found_bytes,
                   out_word.found_bytes);
            fails++;
          end
          if (out_word.found_tokens !== want.found_tokens) begin
            $error("found_tokens: expected %0h, got %0h", want.found_tokens,
                   out_word.found_tokens);
            fails++;
          end
          if (out_word.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, out_word.evicted);
            fails++;
          end
          if (out_word.evicted_hash !== want.evicted_hash) begin
            $error("evicted_hash: expected %0h, got %0h", want.evicted_hash,
                   out_word.evicted_hash);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && !in_stall) pending_results.push_back(index_step(in_data));
    end
    pending = pending_results.size();
  end

endmodule

### test/keyed_index_oldest_eviction_tb.sv
// keyed_index_oldest_eviction_tb: drives store, lookup, remove and spare-kind words into the
// keyed index under several entry limits and idle patterns; keyed_index_checker judges.
// Depends on kio_pkg, keyed_index_oldest_eviction and keyed_index_checker.
module keyed_index_oldest_eviction_tb;
  import kio_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int POOL_MAX = 96;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIM_W-1:0]   cfg_data  = '0;

  int fails;
  int pending;
  int snd_idle;
  int rcv_idle;
  int pool_n;
  int store_pct;
  logic [KEY_W-1:0] key_pool [POOL_MAX];

  keyed_index_oldest_eviction u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  keyed_index_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic put(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                     input logic [BYTES_W-1:0] bytes, input logic [TOK_W-1:0] tokens,
                     input logic [BYTES_W-1:0] room);
    in_word_t w;
    w.kind = kind;
    w.key_hash = key;
    w.blob_bytes = bytes;
    w.prefix_tokens = tokens;
    w.room_bytes = room;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    int r;
    int rest;
    rest = 100 - store_pct;
    r = $urandom_range(0, 99);
    if (r < store_pct) w.kind = KIND_STORE;
    else if (r < store_pct + rest * 6 / 10) w.kind = KIND_LOOKUP;
    else if (r < store_pct + rest * 9 / 10) w.kind = KIND_REMOVE;
    else w.kind = KIND_SPARE;
    if ($urandom_range(0, 99) < 88) w.key_hash = key_pool[$urandom_range(0, pool_n - 1)];
    else w.key_hash = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (r < 4) w.blob_bytes = '0;
    else if (r < 70) w.blob_bytes = $urandom_range(1, 4096);
    else w.blob_bytes = $urandom;
    w.prefix_tokens = TOK_W'($urandom_range(0, 32'h000F_FFFF));
    r = $urandom_range(0, 99);
    if (r < 45) w.room_bytes = $urandom_range(0, 8192);
    else if (r < 70) w.room_bytes = '1;
    else w.room_bytes = $urandom;
    return w;
  endfunction

  task automatic run_batch(input int n_items, input int pool, input int st_pct);
    pool_n = pool;
    store_pct = st_pct;
    for (int i = 0; i < n_items; i++) send_word(rand_word());
    drain();
  endtask

  initial begin
    #12000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_MAX; i++) key_pool[i] = {$urandom, $urandom};
    snd_idle = 13;
    rcv_idle = 47;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put(KIND_STORE,  key_pool[0], '0, 20'h12345, '1);
    put(KIND_LOOKUP, key_pool[0], '0, '0, '1);
    put(KIND_STORE,  key_pool[0], '1, '1, '0);
    put(KIND_LOOKUP, key_pool[0], '0, '0, 32'hFFFF_FFFE);
    put(KIND_LOOKUP, key_pool[0], '0, '0, '1);
    put(KIND_STORE,  key_pool[1], 32'd1, '0, '1);
    put(KIND_LOOKUP, key_pool[1], '1, '1, '0);
    put(KIND_LOOKUP, key_pool[1], '0, '0, 32'd1);
    put(KIND_STORE,  key_pool[1], 32'd100, 20'd12345, '0);
    put(KIND_LOOKUP, key_pool[1], '0, '0, 32'd100);
    put(KIND_LOOKUP, key_pool[1], '0, '0, 32'd99);
    put(KIND_REMOVE, key_pool[1], '1, '1, '1);
    put(KIND_REMOVE, key_pool[1], '0, '0, '0);
    put(KIND_LOOKUP, key_pool[1], '0, '0, '1);
    put(KIND_SPARE,  key_pool[0], '1, '1, '1);
    put(KIND_SPARE,  '1, '0, '0, '0);
    put(KIND_LOOKUP, key_pool[0], '0, '0, '1);
    put(KIND_STORE,  key_pool[2], 32'd7, 20'd3, '0);
    put(KIND_REMOVE, key_pool[3], '0, '0, '0);
    put(KIND_LOOKUP, key_pool[2], '0, '0, 32'd7);
    drain();

    write_limit(7'd3);
    run_batch(100, 8, 50);
    write_limit(7'd0);
    run_batch(30, 6, 50);
    run_batch(30, 6, 50);

    snd_idle = 47;
    rcv_idle = 13;
    write_limit(7'd64);
    run_batch(100, POOL_MAX, 85);
    write_limit(7'd5);
    run_batch(100, POOL_MAX, 50);

    snd_idle = 0;
    rcv_idle = 0;
    write_limit(7'd127);
    run_batch(80, 40, 55);
    write_limit(7'd1);
    run_batch(60, 4, 50);
    write_limit(7'($urandom_range(0, 127)));
    run_batch(100, 24, 50);

    repeat (150) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
